// ===== hdl/gacc_pkg.sv =====
// ----------------------------------------------------------------------------
// gacc_pkg
// Shared constants, codes and controller/datapath interface types for the
// grid arrow cycle counter.
// ----------------------------------------------------------------------------
package gacc_pkg;

	// Default grid limits.
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// Register file.
	localparam int CFG_W       = 7;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
	localparam logic REG_ROWS  = 1'b0;
	localparam logic REG_COLS  = 1'b1;

	// Result field widths.
	localparam int ZONE_W = 12;
	localparam logic [ZONE_W-1:0] ZONE_MAX = 12'd4095;

	// Arrow directions.
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// Per-cell walk marks.
	localparam logic [1:0] MARK_FREE = 2'd0;
	localparam logic [1:0] MARK_PATH = 2'd1;
	localparam logic [1:0] MARK_DONE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_init;
		logic clr_step;
		logic load_wr;
		logic scan_init;
		logic scan_next;
		logic walk_begin;
		logic eval;
		logic take;
		logic hit;
		logic set_off;
		logic pop_rd;
		logic pop_wr;
	} gacc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       load_last;
		logic       clr_last;
		logic       scan_done;
		logic       depth_zero;
		logic       step_off;
		logic [1:0] mark;
	} gacc_status_t;

endpackage

// ===== hdl/gacc_ram.sv =====
// ----------------------------------------------------------------------------
// gacc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gacc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/gacc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gacc_ctrl
// Controller state machine: clearing pass, grid load, scan, walk and unwind.
// ----------------------------------------------------------------------------
module gacc_ctrl
	import gacc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  gacc_status_t status,
	output gacc_cmd_t    cmd,
	output logic         busy,
	output logic         done
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_LOAD,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_ARROW_RD,
		S_EVAL,
		S_NEXT_CHK,
		S_POP_RD,
		S_POP_WR
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_d;
	logic   done_q;

	// Next state and commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (start) begin
					cmd.load_wr = 1'b1;
					if (status.load_last) begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: begin
				if (status.scan_done) begin
					cmd.clr_init = 1'b1;
					done_d       = 1'b1;
					state_d      = S_CLEAR;
				end else begin
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (status.mark != MARK_FREE) begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCAN_RD;
				end else begin
					cmd.walk_begin = 1'b1;
					state_d        = S_ARROW_RD;
				end
			end
			S_ARROW_RD: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (status.step_off) begin
					cmd.set_off = 1'b1;
					state_d     = S_POP_RD;
				end else begin
					cmd.eval = 1'b1;
					state_d  = S_NEXT_CHK;
				end
			end
			S_NEXT_CHK: begin
				if (status.mark == MARK_FREE) begin
					cmd.take = 1'b1;
					state_d  = S_ARROW_RD;
				end else begin
					cmd.hit = 1'b1;
					state_d = S_POP_RD;
				end
			end
			S_POP_RD: begin
				if (status.depth_zero) begin
					cmd.scan_next = 1'b1;
					state_d       = S_SCAN_RD;
				end else begin
					cmd.pop_rd = 1'b1;
					state_d    = S_POP_WR;
				end
			end
			S_POP_WR: begin
				cmd.pop_wr = 1'b1;
				state_d    = S_POP_RD;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// State and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_LOAD);
	assign done = done_q;

endmodule

// ===== hdl/gacc_dp.sv =====
// ----------------------------------------------------------------------------
// gacc_dp
// Datapath: arrow, mark and path stack memories, position counters, the
// neighbor step and the cycle count.
// ----------------------------------------------------------------------------
module gacc_dp
	import gacc_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gacc_cmd_t                          cmd,
	input  logic                               cfg_wr,
	input  logic [$clog2(MAX_ROWS+1)-1:0]      rows,
	input  logic [$clog2(MAX_COLS+1)-1:0]      cols,
	input  logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0] total,
	input  logic [1:0]                         direction,
	output gacc_status_t                       status,
	output logic [ZONE_W-1:0]                  zone_count,
	output logic                               off_grid_error
);

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam int COL_W = $clog2(MAX_COLS + 1);
	localparam int RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CI_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [CNT_W-1:0]  load_pos_q;
	logic [CNT_W-1:0]  clr_addr_q;
	logic [CNT_W-1:0]  clr_end_q;
	logic [CNT_W-1:0]  start_idx_q;
	logic [RI_W-1:0]   start_r_q;
	logic [CI_W-1:0]   start_c_q;
	logic [IDX_W-1:0]  cur_idx_q;
	logic [RI_W-1:0]   cur_r_q;
	logic [CI_W-1:0]   cur_c_q;
	logic [IDX_W-1:0]  nxt_idx_q;
	logic [RI_W-1:0]   nxt_r_q;
	logic [CI_W-1:0]   nxt_c_q;
	logic [CNT_W-1:0]  depth_q;
	logic [ZONE_W-1:0] count_q;
	logic              off_q;

	logic [IDX_W-1:0]  step_idx;
	logic [RI_W-1:0]   step_r;
	logic [CI_W-1:0]   step_c;
	logic              step_off;
	logic [CNT_W-1:0]  cur_wide;
	logic              top_row;
	logic              bot_row;
	logic              left_col;
	logic              right_col;

	logic [1:0]        arrow_rdata;
	logic              mark_we;
	logic [IDX_W-1:0]  mark_waddr;
	logic [1:0]        mark_wdata;
	logic [IDX_W-1:0]  mark_raddr;
	logic [1:0]        mark_rdata;
	logic              stack_we;
	logic [IDX_W-1:0]  stack_waddr;
	logic [IDX_W-1:0]  stack_wdata;
	logic [IDX_W-1:0]  stack_rdata;
	logic [CNT_W-1:0]  depth_m1;

	// Neighbor of the current cell and the off-grid check.
	assign cur_wide  = CNT_W'(cur_idx_q);
	assign top_row   = (cur_r_q == '0);
	assign bot_row   = ((ROW_W'(cur_r_q) + ROW_W'(1)) == rows);
	assign left_col  = (cur_c_q == '0);
	assign right_col = ((COL_W'(cur_c_q) + COL_W'(1)) == cols);

	always_comb begin
		step_r   = cur_r_q;
		step_c   = cur_c_q;
		step_idx = cur_idx_q;
		step_off = 1'b0;
		case (arrow_rdata)
			DIR_UP: begin
				step_off = top_row;
				step_r   = cur_r_q - RI_W'(1);
				step_idx = IDX_W'(cur_wide - CNT_W'(cols));
			end
			DIR_RIGHT: begin
				step_off = right_col;
				step_c   = cur_c_q + CI_W'(1);
				step_idx = IDX_W'(cur_wide + CNT_W'(1));
			end
			DIR_DOWN: begin
				step_off = bot_row;
				step_r   = cur_r_q + RI_W'(1);
				step_idx = IDX_W'(cur_wide + CNT_W'(cols));
			end
			default: begin
				step_off = left_col;
				step_c   = cur_c_q - CI_W'(1);
				step_idx = IDX_W'(cur_wide - CNT_W'(1));
			end
		endcase
	end

	// Mark memory port selection.
	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = IDX_W'(clr_addr_q);
		mark_wdata = MARK_FREE;
		if (cmd.clr_step) begin
			mark_we = 1'b1;
		end else if (cmd.walk_begin) begin
			mark_we    = 1'b1;
			mark_waddr = IDX_W'(start_idx_q);
			mark_wdata = MARK_PATH;
		end else if (cmd.take) begin
			mark_we    = 1'b1;
			mark_waddr = nxt_idx_q;
			mark_wdata = MARK_PATH;
		end else if (cmd.pop_wr) begin
			mark_we    = 1'b1;
			mark_waddr = stack_rdata;
			mark_wdata = MARK_DONE;
		end
		mark_raddr = cmd.eval ? step_idx : IDX_W'(start_idx_q);
	end

	// Path stack port selection.
	assign depth_m1    = depth_q - CNT_W'(1);
	assign stack_we    = cmd.walk_begin | cmd.take;
	assign stack_waddr = cmd.walk_begin ? '0 : IDX_W'(depth_q);
	assign stack_wdata = cmd.walk_begin ? IDX_W'(start_idx_q) : nxt_idx_q;

	gacc_ram #(.WIDTH(2), .DEPTH(CELLS)) u_arrow (
		.clk   (clk),
		.we    (cmd.load_wr),
		.waddr (IDX_W'(load_pos_q)),
		.wdata (direction),
		.raddr (cur_idx_q),
		.rdata (arrow_rdata)
	);

	gacc_ram #(.WIDTH(2), .DEPTH(CELLS)) u_mark (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.raddr (mark_raddr),
		.rdata (mark_rdata)
	);

	gacc_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_stack (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_waddr),
		.wdata (stack_wdata),
		.raddr (IDX_W'(depth_m1)),
		.rdata (stack_rdata)
	);

	// Counters, walk position and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q  <= '0;
			clr_addr_q  <= '0;
			clr_end_q   <= CNT_W'(CELLS);
			start_idx_q <= '0;
			start_r_q   <= '0;
			start_c_q   <= '0;
			cur_idx_q   <= '0;
			cur_r_q     <= '0;
			cur_c_q     <= '0;
			nxt_idx_q   <= '0;
			nxt_r_q     <= '0;
			nxt_c_q     <= '0;
			depth_q     <= '0;
			count_q     <= '0;
			off_q       <= 1'b0;
		end else begin
			// Grid load position restarts on a register write or a full grid.
			if (cfg_wr) begin
				load_pos_q <= '0;
			end else if (cmd.load_wr) begin
				load_pos_q <= status.load_last ? '0 : load_pos_q + CNT_W'(1);
			end
			// Clearing pass over the marks.
			if (cmd.clr_init) begin
				clr_addr_q <= '0;
				clr_end_q  <= total;
			end else if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + CNT_W'(1);
			end
			// Scan over start cells in row-major order.
			if (cmd.scan_init) begin
				start_idx_q <= '0;
				start_r_q   <= '0;
				start_c_q   <= '0;
				count_q     <= '0;
				off_q       <= 1'b0;
				depth_q     <= '0;
			end else if (cmd.scan_next) begin
				start_idx_q <= start_idx_q + CNT_W'(1);
				if ((COL_W'(start_c_q) + COL_W'(1)) == cols) begin
					start_c_q <= '0;
					start_r_q <= start_r_q + RI_W'(1);
				end else begin
					start_c_q <= start_c_q + CI_W'(1);
				end
			end
			// Walk: begin, step, hit and unwind.
			if (cmd.walk_begin) begin
				cur_idx_q <= IDX_W'(start_idx_q);
				cur_r_q   <= start_r_q;
				cur_c_q   <= start_c_q;
				depth_q   <= CNT_W'(1);
			end
			if (cmd.eval) begin
				nxt_idx_q <= step_idx;
				nxt_r_q   <= step_r;
				nxt_c_q   <= step_c;
			end
			if (cmd.take) begin
				cur_idx_q <= nxt_idx_q;
				cur_r_q   <= nxt_r_q;
				cur_c_q   <= nxt_c_q;
				depth_q   <= depth_q + CNT_W'(1);
			end
			if (cmd.hit && (mark_rdata == MARK_PATH) && (count_q != ZONE_MAX)) begin
				count_q <= count_q + ZONE_W'(1);
			end
			if (cmd.set_off) begin
				off_q <= 1'b1;
			end
			if (cmd.pop_rd) begin
				depth_q <= depth_m1;
			end
		end
	end

	// Status back to the controller.
	assign status.load_last  = (load_pos_q == (total - CNT_W'(1)));
	assign status.clr_last   = ((clr_addr_q + CNT_W'(1)) == clr_end_q);
	assign status.scan_done  = (start_idx_q == total);
	assign status.depth_zero = (depth_q == '0);
	assign status.step_off   = step_off;
	assign status.mark       = mark_rdata;

	assign zone_count     = off_q ? '0 : count_q;
	assign off_grid_error = off_q;

endmodule

// ===== hdl/grid_arrow_cycle_counter_core.sv =====
// ----------------------------------------------------------------------------
// grid_arrow_cycle_counter_core
// Loads a grid of arrow cells and counts the cycles of the arrow graph.
// ----------------------------------------------------------------------------
//  Channel   | Signals                                   | Handshake
//  ----------+-------------------------------------------+--------------------
//  request   | start, busy, direction                    | start & !busy
//  result    | done, zone_count, off_grid_error          | done, one cycle
//  registers | psel, penable, pwrite, paddr, pwdata,     | APB write on
//            | prdata, pready                            | psel&penable&pwrite
//
// Cell requests with busy low are taken back to back, each writing its arrow to the
// arrow memory. The last cell starts the count: the scan of start cells, each walk
// step and each unwound path entry wait on the registered reads of the mark, arrow
// and path stack memories. After each result a clearing pass resets the marks of
// rows*cols cells; after reset the pass covers MAX_ROWS*MAX_COLS cells. The receiver
// cannot stall: done is high for one cycle per result.
// ----------------------------------------------------------------------------
module grid_arrow_cycle_counter_core
	import gacc_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        direction,
	output logic              done,
	output logic [ZONE_W-1:0] zone_count,
	output logic              off_grid_error,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);
	localparam int ROW_W = $clog2(MAX_ROWS + 1);
	localparam int COL_W = $clog2(MAX_COLS + 1);

	logic [CFG_W-1:0] grid_rows_q;
	logic [CFG_W-1:0] grid_cols_q;
	logic             cfg_wr;
	logic [ROW_W-1:0] rows_eff;
	logic [COL_W-1:0] cols_eff;
	logic [CNT_W-1:0] total;
	gacc_cmd_t        cmd;
	gacc_status_t     status;

	// Register writes.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= CFG_RESET;
			grid_cols_q <= CFG_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ROWS) begin
				grid_rows_q <= pwdata[CFG_W-1:0];
			end else begin
				grid_cols_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	// Register reads.
	assign prdata = (paddr[2] == REG_ROWS) ? APB_DW'(grid_rows_q) : APB_DW'(grid_cols_q);

	// Effective grid size: zero acts as one, large values clamp to the maximum.
	always_comb begin
		if (grid_rows_q == '0) begin
			rows_eff = ROW_W'(1);
		end else if (int'(grid_rows_q) > MAX_ROWS) begin
			rows_eff = ROW_W'(MAX_ROWS);
		end else begin
			rows_eff = ROW_W'(grid_rows_q);
		end
		if (grid_cols_q == '0) begin
			cols_eff = COL_W'(1);
		end else if (int'(grid_cols_q) > MAX_COLS) begin
			cols_eff = COL_W'(MAX_COLS);
		end else begin
			cols_eff = COL_W'(grid_cols_q);
		end
	end

	// The product is formed at full count width.
	assign total = CNT_W'(rows_eff) * CNT_W'(cols_eff);

	gacc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gacc_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_wr         (cfg_wr),
		.rows           (rows_eff),
		.cols           (cols_eff),
		.total          (total),
		.direction      (direction),
		.status         (status),
		.zone_count     (zone_count),
		.off_grid_error (off_grid_error)
	);

endmodule

// ===== hdl/gacc_checker.sv =====
// ----------------------------------------------------------------------------
// gacc_checker
// Port-level checks on the grid arrow cycle counter, bound to the top level.
// ----------------------------------------------------------------------------
module gacc_checker
	import gacc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              busy,
	input logic              done,
	input logic [ZONE_W-1:0] zone_count,
	input logic              off_grid_error,
	input logic              pready
);

	// A result appears only while the block is busy with its clearing pass.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	// Results never come in two consecutive cycles.
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back result strobes");

	// An off-grid arrow forces a zero count.
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && off_grid_error) |-> (zone_count == '0))
		else $error("nonzero count with off-grid error");

	// The block is busy in the cycle before each result.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(busy)) else $error("result without prior work");

	// The register port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");

endmodule

bind grid_arrow_cycle_counter_core gacc_checker u_gacc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.busy           (busy),
	.done           (done),
	.zone_count     (zone_count),
	.off_grid_error (off_grid_error),
	.pready         (pready)
);
